@@ hdl/sfx_pkg.sv @@
package sfx_pkg;

   localparam int FIELD_COUNT = 6;
   localparam int FIELD_BYTES = 4 * FIELD_COUNT;

   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_FIRST   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_SECOND  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FIELD_OFFSET = 2'd2;

   localparam logic [7:0] SYNC_FIRST_RESET   = 8'h55;
   localparam logic [7:0] SYNC_SECOND_RESET  = 8'hAA;
   localparam logic [7:0] FIELD_OFFSET_RESET = 8'd10;

   typedef struct packed {
      logic [7:0] sync_first;
      logic [7:0] sync_second;
      logic [7:0] first_field_offset;
   } cfg_type;

   typedef struct packed {
      logic [3:0]  field_number;
      logic [31:0] field_word;
      logic        frame_done;
   } result_type;

endpackage

@@ hdl/sfx_if.sv @@
interface sfx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfx_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  field_number;
   logic [31:0] field_word;
   logic        frame_done;

   modport source (output valid, output field_number, output field_word,
                   output frame_done, input ready);
   modport sink   (input valid, input field_number, input field_word,
                   input frame_done, output ready);
endinterface

interface sfx_csr_if;
   import sfx_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [7:0]           data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/sfx_csr.sv @@
module sfx_csr (
   input  logic             clock,
   input  logic             reset,
   sfx_csr_if.sink          csr_ch,
   output sfx_pkg::cfg_type cfg
);
   import sfx_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_SYNC_FIRST:   cfg_in.sync_first         = csr_ch.data;
            CSR_SYNC_SECOND:  cfg_in.sync_second        = csr_ch.data;
            CSR_FIELD_OFFSET: cfg_in.first_field_offset = csr_ch.data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_first         <= SYNC_FIRST_RESET;
         cfg_ff.sync_second        <= SYNC_SECOND_RESET;
         cfg_ff.first_field_offset <= FIELD_OFFSET_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule

@@ hdl/sfx_parse.sv @@
module sfx_parse (
   input  logic                clock,
   input  logic                reset,
   sfx_req_if.sink             req_ch,
   input  sfx_pkg::cfg_type    cfg,
   input  logic                out_free,
   output logic                res_load,
   output sfx_pkg::result_type res
);
   import sfx_pkg::*;

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        advance;

   logic        armed_ff, armed_in;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  prev_ff, prev_in;
   logic [23:0] partial_ff, partial_in;

   logic [7:0]  off;
   logic [7:0]  cnt;
   logic [7:0]  rel;
   logic        produced;

   // The held byte is processed once the result register can take its transfer.
   assign advance      = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ch.valid && req_ch.ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      armed_in   = armed_ff;
      count_in   = count_ff;
      partial_in = partial_ff;
      prev_in    = in_byte_ff;
      produced   = 1'b0;
      off        = (cfg.first_field_offset == 8'd0) ? 8'd1 : cfg.first_field_offset;
      cnt        = count_ff + 8'd1;
      rel        = cnt - off;

      res.field_number = rel[5:2];
      res.field_word   = {in_byte_ff, partial_ff};
      res.frame_done   = (rel[5:2] == 4'(FIELD_COUNT - 1));

      if (armed_ff) begin
         if (count_ff == 8'hFF) begin
            // The counter cannot reach the rest of the frame, so give it up.
            armed_in = 1'b0;
            count_in = 8'd0;
         end else begin
            count_in = cnt;
            if (cnt >= off && rel < 8'(FIELD_BYTES)) begin
               case (rel[1:0])
                  2'd0:    partial_in[7:0]   = in_byte_ff;
                  2'd1:    partial_in[15:8]  = in_byte_ff;
                  2'd2:    partial_in[23:16] = in_byte_ff;
                  default: begin
                     produced = 1'b1;
                     if (res.frame_done) begin
                        armed_in = 1'b0;
                     end
                  end
               endcase
            end
         end
      end

      // The sync test looks at the flag after this byte, so a frame can re-arm at once.
      if (!armed_in && prev_ff == cfg.sync_first && in_byte_ff == cfg.sync_second) begin
         armed_in = 1'b1;
         count_in = 8'd0;
      end
   end

   assign res_load = advance && produced;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         armed_ff    <= 1'b0;
         count_ff    <= 8'd0;
         prev_ff     <= 8'd0;
         partial_ff  <= 24'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            armed_ff   <= armed_in;
            count_ff   <= count_in;
            prev_ff    <= prev_in;
            partial_ff <= partial_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_byte_ff <= req_ch.rx_byte;
      end
   end
endmodule

@@ hdl/sfx_out.sv @@
module sfx_out (
   input  logic                clock,
   input  logic                reset,
   input  logic                res_load,
   input  sfx_pkg::result_type res,
   output logic                out_free,
   sfx_rsp_if.source           rsp_ch
);
   import sfx_pkg::*;

   logic       out_valid_ff, out_valid_in;
   result_type out_ff;

   assign out_free = !out_valid_ff || rsp_ch.ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (res_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         out_ff <= res;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.field_number = out_ff.field_number;
   assign rsp_ch.field_word   = out_ff.field_word;
   assign rsp_ch.frame_done   = out_ff.frame_done;
endmodule

@@ hdl/sync_header_frame_field_extractor.sv @@
// Frame field extractor: takes one received byte per transfer and may accept a new
// byte every clock cycle unless stalled as below. A byte is held in an input register,
// then compare-and-shift logic updates the sync, counter and word-assembly state and,
// when a word's fourth byte arrives, loads the result register once that is free, so
// a word reaches the result channel through the input and result registers. The stall
// comes only from the result register: while it holds an untaken word, at most one
// more byte is held.
// Registers are written through the csr channel, which is always ready.
module sync_header_frame_field_extractor (
   input  logic      clock,
   input  logic      reset,
   sfx_req_if.sink   req_ch,
   sfx_rsp_if.source rsp_ch,
   sfx_csr_if.sink   csr_ch
);
   import sfx_pkg::*;

   cfg_type    cfg;
   result_type res;
   logic       res_load;
   logic       out_free;

   sfx_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   sfx_parse u_parse (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .cfg      (cfg),
      .out_free (out_free),
      .res_load (res_load),
      .res      (res)
   );

   sfx_out u_out (
      .clock    (clock),
      .reset    (reset),
      .res_load (res_load),
      .res      (res),
      .out_free (out_free),
      .rsp_ch   (rsp_ch)
   );

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.frame_done |-> rsp_ch.field_number == 4'(FIELD_COUNT - 1))
      else $error("frame end flagged on a word other than the last");

   a_number_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> rsp_ch.field_number < 4'(FIELD_COUNT))
      else $error("word index beyond the frame");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> rsp_ch.valid && !rsp_ch.ready)
      else $error("input stalled without a waiting result");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      res_load |-> out_free)
      else $error("result register overwritten before its transfer");
endmodule
